// ===== rtl/core/softmax_exp_numerator_defines.svh =====
// assertion macros for the softmax exponent numerator checker
`ifndef SOFTMAX_EXP_NUMERATOR_DEFINES_SVH
`define SOFTMAX_EXP_NUMERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SXN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SXN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sxn_pkg.sv =====
// shared constants for the softmax exponent numerator
package sxn_pkg;

  // pipeline depth of one fused multiply-add unit
  localparam int unsigned FmaLat = 5;

  // config address decode
  localparam int unsigned PaddrW      = 3;
  localparam logic        RegMaxLogit = 1'b0;

  // binary32 constants
  localparam logic [31:0] FpOne       = 32'h3F80_0000;
  localparam logic [31:0] FpShifter   = 32'h4B40_0000;
  localparam logic [31:0] FpLog2e     = 32'h3FB8_AA3B;
  localparam logic [31:0] FpLn2Hi     = 32'h3F31_7200;
  localparam logic [31:0] FpLn2Lo     = 32'h35BF_BE8E;
  localparam logic [31:0] FpC5        = 32'h3C07_2010;
  localparam logic [31:0] FpC4        = 32'h3D2B_9F17;
  localparam logic [31:0] FpC3        = 32'h3E2A_AF33;
  localparam logic [31:0] FpC2        = 32'h3EFF_FEDB;
  localparam logic [31:0] FpC1        = 32'h3F7F_FFF6;
  localparam logic [30:0] FpSplitLim  = 31'h42FC_0000;
  localparam logic [30:0] FpHugeLim   = 31'h4340_0000;
  localparam logic [31:0] NegBias     = 32'h8200_0000;
  localparam logic [31:0] S1Base      = 32'h7F00_0000;
  localparam logic [31:0] FpPosInf    = 32'h7F80_0000;
  localparam logic [31:0] FpNegZero   = 32'h8000_0000;
  localparam logic [31:0] FpSignMask  = 32'h8000_0000;
  localparam logic [31:0] FpQuietBit  = 32'h0040_0000;
  localparam logic [31:0] FpNanSubInf = 32'hFFC0_0000;
  localparam logic [31:0] FpNanFma    = 32'h7FC0_0000;

endpackage

// ===== rtl/core/sxn_in_if.sv =====
// input channel: one logit per transaction
interface sxn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] logit;
  logic        is_last;

  modport source (output valid, output logit, output is_last, input ready);
  modport sink   (input valid, input logit, input is_last, output ready);
endinterface

// ===== rtl/core/sxn_out_if.sv =====
// output channel: one exponent result per transaction
interface sxn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] exp_value;
  logic        last_out;

  modport source (output valid, output exp_value, output last_out, input ready);
  modport sink   (input valid, input exp_value, input last_out, output ready);
endinterface

// ===== rtl/core/sxn_fma.sv =====
// binary32 fused multiply-add a*b+c, single rounding to nearest even, five stages
module sxn_fma
  import sxn_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] res_o
);

  // leading zero count of a 24-bit significand
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // normalized operand: {signed exponent, significand with msb set}
  function automatic logic [33:0] norm_op(input logic [31:0] f);
    logic [23:0] m;
    logic [4:0]  lz;
    logic [9:0]  e;
    m  = {(f[30:23] != 8'd0), f[22:0]};
    lz = lzc24(m);
    e  = (f[30:23] == 8'd0) ? 10'd1 : {2'b00, f[30:23]};
    e  = e - {5'd0, lz};
    return {e, m << lz};
  endfunction

  // ---------------- stage a: classify and normalize
  logic a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
  logic p_sign, p_nan, p_inf;
  logic        spec_a;
  logic [31:0] spec_val_a;
  logic [33:0] na, nb, nc;

  assign a_zero = (a_i[30:0] == 31'd0);
  assign b_zero = (b_i[30:0] == 31'd0);
  assign c_zero = (c_i[30:0] == 31'd0);
  assign a_inf  = (a_i[30:0] == FpPosInf[30:0]);
  assign b_inf  = (b_i[30:0] == FpPosInf[30:0]);
  assign c_inf  = (c_i[30:0] == FpPosInf[30:0]);
  assign a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
  assign b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
  assign c_nan  = (c_i[30:23] == 8'hFF) && (c_i[22:0] != 23'd0);
  assign p_sign = a_i[31] ^ b_i[31];
  assign p_nan  = a_nan | b_nan | c_nan | (a_inf & b_zero) | (a_zero & b_inf);
  assign p_inf  = a_inf | b_inf;
  assign na     = norm_op(a_i);
  assign nb     = norm_op(b_i);
  assign nc     = norm_op(c_i);

  // results that bypass the datapath
  always_comb begin
    spec_a     = 1'b1;
    spec_val_a = FpNanFma;
    if (p_nan || (p_inf && c_inf && (p_sign != c_i[31]))) begin
      spec_val_a = FpNanFma;
    end else if (p_inf) begin
      spec_val_a = {p_sign, FpPosInf[30:0]};
    end else if (c_inf) begin
      spec_val_a = c_i;
    end else if (a_zero || b_zero) begin
      spec_val_a = c_zero ? {p_sign & c_i[31], 31'd0} : c_i;
    end else begin
      spec_a = 1'b0;
    end
  end

  logic [23:0] ma_q, mb_q, mc_q;
  logic [9:0]  ea_q, eb_q, ec_q;
  logic        sp_a_q, sc_a_q, cz_a_q, spec_a_q;
  logic [31:0] spec_val_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q         <= na[23:0];
      mb_q         <= nb[23:0];
      mc_q         <= nc[23:0];
      ea_q         <= na[33:24];
      eb_q         <= nb[33:24];
      ec_q         <= nc[33:24];
      sp_a_q       <= p_sign;
      sc_a_q       <= c_i[31];
      cz_a_q       <= c_zero;
      spec_a_q     <= spec_a;
      spec_val_a_q <= spec_val_a;
    end
  end

  // ---------------- stage b: significand product
  logic [47:0]        mp;
  logic signed [11:0] xp, xc;

  assign mp = ma_q * mb_q;
  assign xp = 12'($signed(ea_q)) + 12'($signed(eb_q)) - 12'sd126;
  assign xc = 12'($signed(ec_q));

  logic [47:0]        mp_q, mc48_q;
  logic signed [11:0] xp_q, xc_q;
  logic               sp_b_q, sc_b_q, cz_b_q, spec_b_q;
  logic [31:0]        spec_val_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mp_q         <= mp;
      mc48_q       <= {mc_q, 24'd0};
      xp_q         <= xp;
      xc_q         <= xc;
      sp_b_q       <= sp_a_q;
      sc_b_q       <= sc_a_q;
      cz_b_q       <= cz_a_q;
      spec_b_q     <= spec_a_q;
      spec_val_b_q <= spec_val_a_q;
    end
  end

  // ---------------- stage c: align and add
  logic signed [11:0] diff, dabs, xbig;
  logic               swap, eff_sub, sbig, ssmall, neg;
  logic [47:0]        big, small_m;
  logic [99:0]        bigw, aligned, dif2;
  logic [100:0]       dif1, sum, r_c;
  logic               rsign_c;

  assign diff    = xp_q - xc_q;
  assign swap    = !cz_b_q && (diff < 12'sd0);
  assign dabs    = swap ? -diff : diff;
  assign xbig    = swap ? xc_q : xp_q;
  assign big     = swap ? mc48_q : mp_q;
  assign small_m = swap ? mp_q : (cz_b_q ? 48'd0 : mc48_q);
  assign sbig    = swap ? sc_b_q : sp_b_q;
  assign ssmall  = swap ? sp_b_q : sc_b_q;
  assign eff_sub = sp_b_q ^ sc_b_q;
  assign bigw    = {big, 52'd0};
  // far-off addend only matters as a sticky bit below everything else
  assign aligned = (dabs >= 12'sd52) ? {99'd0, (small_m != 48'd0)}
                                     : ({small_m, 52'd0} >> dabs[5:0]);
  assign dif1    = {1'b0, bigw} - {1'b0, aligned};
  assign dif2    = aligned - bigw;
  assign sum     = {1'b0, bigw} + {1'b0, aligned};
  assign neg     = dif1[100];
  assign r_c     = eff_sub ? (neg ? {1'b0, dif2} : dif1) : sum;
  assign rsign_c = (eff_sub && neg) ? ssmall : sbig;

  logic [100:0]       r_c_q;
  logic signed [11:0] xbig_q;
  logic               rsign_c_q, spec_c_q;
  logic [31:0]        spec_val_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_c_q        <= r_c;
      xbig_q       <= xbig;
      rsign_c_q    <= rsign_c;
      spec_c_q     <= spec_b_q;
      spec_val_c_q <= spec_val_b_q;
    end
  end

  // ---------------- stage d: leading one and rounding position
  logic [6:0]         msb;
  logic signed [11:0] q_norm, q_sub, q_sel, eenc;
  logic [6:0]         qc;

  always_comb begin
    msb = 7'd0;
    for (int i = 0; i < 101; i++) begin
      if (r_c_q[i]) msb = 7'(i);
    end
  end

  assign q_norm = 12'($signed({5'd0, msb})) - 12'sd23;
  assign q_sub  = 12'sd77 - xbig_q;
  assign q_sel  = (q_norm > q_sub) ? q_norm : q_sub;
  assign eenc   = q_sel + xbig_q - 12'sd77;
  assign qc     = (q_sel < 12'sd0)   ? 7'd0   :
                  (q_sel > 12'sd102) ? 7'd102 : q_sel[6:0];

  logic [100:0] r_d_q;
  logic [6:0]   qc_q;
  logic [9:0]   eenc_q;
  logic         rsign_d_q, rzero_q, spec_d_q;
  logic [31:0]  spec_val_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_d_q        <= r_c_q;
      qc_q         <= qc;
      eenc_q       <= eenc[9:0];
      rsign_d_q    <= rsign_c_q;
      rzero_q      <= (r_c_q == 101'd0);
      spec_d_q     <= spec_c_q;
      spec_val_d_q <= spec_val_c_q;
    end
  end

  // ---------------- stage e: shift, round, pack
  logic [101:0] shr;
  logic [100:0] low_mask;
  logic [23:0]  m24;
  logic         rnd_bit, sticky, inc;
  logic [33:0]  mag;
  logic [31:0]  res_e;

  assign shr      = {r_d_q, 1'b0} >> qc_q;
  assign m24      = shr[24:1];
  assign rnd_bit  = shr[0];
  assign low_mask = (~({101{1'b1}} << qc_q)) >> 1;
  assign sticky   = ((r_d_q & low_mask) != 101'd0);
  assign inc      = rnd_bit & (sticky | m24[0]);
  assign mag      = {1'b0, eenc_q, 23'd0} + {10'd0, m24} + {33'd0, inc};

  always_comb begin
    if (spec_d_q) begin
      res_e = spec_val_d_q;
    end else if (rzero_q) begin
      res_e = 32'd0;
    end else if (mag >= {2'b00, FpPosInf}) begin
      res_e = {rsign_d_q, FpPosInf[30:0]};
    end else begin
      res_e = {rsign_d_q, mag[30:0]};
    end
  end

  logic [31:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_e;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/softmax_exp_numerator.sv =====
// top level: exp(logit - peak logit) for softmax numerators, fully pipelined
//
//   channel   direction  handshake           payload
//   in_i      in         valid/ready         logit[31:0], is_last
//   out_o     out        valid/ready         exp_value[31:0], last_out
//   apb       in/out     psel/penable/pready peak logit at byte address 0
//
// one transaction per cycle sustained while out_o accepts; the longest path runs
// through ten chained five-stage fused multiply-add units plus the output register.
// all stages move together; when out_o is held, in_i.ready drops until it drains.
// reset clears the valid pipeline and sets the peak logit to +0.0.
module softmax_exp_numerator
  import sxn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sxn_in_if.sink            in_i,
  sxn_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned L      = FmaLat;
  localparam int unsigned OutLat = 10 * L + 1;

  // ---------------- config register
  logic [31:0] peak_logit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_logit_q <= 32'd0;
    end else if (psel && penable && pwrite && (paddr[2] == RegMaxLogit)) begin
      peak_logit_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxLogit) ? peak_logit_q : 32'd0;

  // ---------------- pipeline advance and valid bits
  logic adv;
  logic vld_q [OutLat];

  assign adv        = !vld_q[OutLat-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OutLat; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i < OutLat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------- nan and infinity cases taken at the input
  logic        l_nan, m_nan, spec_in;
  logic [31:0] spec_val_in;

  assign l_nan = (in_i.logit[30:23] == 8'hFF) && (in_i.logit[22:0] != 23'd0);
  assign m_nan = (peak_logit_q[30:23] == 8'hFF) && (peak_logit_q[22:0] != 23'd0);

  always_comb begin
    spec_in     = 1'b1;
    spec_val_in = FpNanSubInf;
    if (l_nan) begin
      spec_val_in = in_i.logit | FpQuietBit;
    end else if (m_nan) begin
      spec_val_in = peak_logit_q | FpQuietBit;
    end else if ((in_i.logit[30:0] == FpPosInf[30:0]) && (in_i.logit == peak_logit_q)) begin
      spec_val_in = FpNanSubInf;
    end else begin
      spec_in = 1'b0;
    end
  end

  // ---------------- argument reduction
  logic [31:0] x, z, n, t1, b;

  sxn_fma u_sub (.clk_i, .en_i(adv), .a_i(in_i.logit), .b_i(FpOne),
                 .c_i(peak_logit_q ^ FpSignMask), .res_o(x));
  sxn_fma u_z   (.clk_i, .en_i(adv), .a_i(x), .b_i(FpLog2e), .c_i(FpShifter), .res_o(z));
  sxn_fma u_n   (.clk_i, .en_i(adv), .a_i(z), .b_i(FpOne),
                 .c_i(FpShifter ^ FpSignMask), .res_o(n));

  logic [31:0] x_dly_q [2*L];
  logic [31:0] z_dly_q [L];
  logic [31:0] n_dly_q [L];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_dly_q[0] <= x;
      for (int i = 1; i < 2*L; i++) x_dly_q[i] <= x_dly_q[i-1];
      z_dly_q[0] <= z;
      n_dly_q[0] <= n;
      for (int i = 1; i < L; i++) begin
        z_dly_q[i] <= z_dly_q[i-1];
        n_dly_q[i] <= n_dly_q[i-1];
      end
    end
  end

  sxn_fma u_t1 (.clk_i, .en_i(adv), .a_i(n ^ FpSignMask), .b_i(FpLn2Hi),
                .c_i(x_dly_q[2*L-1]), .res_o(t1));
  sxn_fma u_b  (.clk_i, .en_i(adv), .a_i(n_dly_q[L-1] ^ FpSignMask), .b_i(FpLn2Lo),
                .c_i(t1), .res_o(b));

  // ---------------- scale factors and range flags from n
  logic        n_nonpos, is_split, is_huge;
  logic [31:0] g32, e32, k, s2, s1;

  assign n_nonpos = n[31] || (n[30:0] == 31'd0);
  assign is_split = (n[30:0] > FpSplitLim);
  assign is_huge  = (n[30:0] > FpHugeLim);
  assign g32      = n_nonpos ? NegBias : 32'd0;
  assign e32      = {z_dly_q[L-1][8:0], 23'd0};
  assign k        = e32 + FpOne;
  assign s2       = e32 - g32;

  logic [31:0] k_dly_q  [5*L];
  logic [31:0] s2_dly_q [5*L];
  logic        g_dly_q  [6*L];
  logic [2:0]  fl_dly_q [7*L];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_dly_q[0]  <= k;
      s2_dly_q[0] <= s2;
      for (int i = 1; i < 5*L; i++) begin
        k_dly_q[i]  <= k_dly_q[i-1];
        s2_dly_q[i] <= s2_dly_q[i-1];
      end
      g_dly_q[0] <= n_nonpos;
      for (int i = 1; i < 6*L; i++) g_dly_q[i] <= g_dly_q[i-1];
      fl_dly_q[0] <= {is_huge, is_split, !n_nonpos};
      for (int i = 1; i < 7*L; i++) fl_dly_q[i] <= fl_dly_q[i-1];
    end
  end

  assign s1 = (g_dly_q[6*L-1] ? NegBias : 32'd0) + S1Base;

  // ---------------- polynomial
  logic [31:0] u, p1, p2, c1b, q1, j;

  sxn_fma u_u   (.clk_i, .en_i(adv), .a_i(b),   .b_i(b), .c_i(FpNegZero), .res_o(u));
  sxn_fma u_p1  (.clk_i, .en_i(adv), .a_i(FpC5), .b_i(b), .c_i(FpC4),     .res_o(p1));
  sxn_fma u_p2  (.clk_i, .en_i(adv), .a_i(FpC3), .b_i(b), .c_i(FpC2),     .res_o(p2));
  sxn_fma u_c1b (.clk_i, .en_i(adv), .a_i(FpC1), .b_i(b), .c_i(FpNegZero), .res_o(c1b));

  logic [31:0] u_dly_q   [L];
  logic [31:0] c1b_dly_q [L];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_dly_q[0]   <= u;
      c1b_dly_q[0] <= c1b;
      for (int i = 1; i < L; i++) begin
        u_dly_q[i]   <= u_dly_q[i-1];
        c1b_dly_q[i] <= c1b_dly_q[i-1];
      end
    end
  end

  sxn_fma u_q1 (.clk_i, .en_i(adv), .a_i(p1), .b_i(u), .c_i(p2), .res_o(q1));
  sxn_fma u_j  (.clk_i, .en_i(adv), .a_i(q1), .b_i(u_dly_q[L-1]),
                .c_i(c1b_dly_q[L-1]), .res_o(j));

  // ---------------- final scaling, direct and split
  logic [31:0] rn, rs1, rs;

  sxn_fma u_rn  (.clk_i, .en_i(adv), .a_i(k_dly_q[5*L-1]), .b_i(j),
                 .c_i(k_dly_q[5*L-1]), .res_o(rn));
  sxn_fma u_rs1 (.clk_i, .en_i(adv), .a_i(s2_dly_q[5*L-1]), .b_i(j),
                 .c_i(s2_dly_q[5*L-1]), .res_o(rs1));
  sxn_fma u_rs  (.clk_i, .en_i(adv), .a_i(rs1), .b_i(s1), .c_i(FpNegZero), .res_o(rs));

  logic [31:0] rn_dly_q   [L];
  logic [32:0] spec_dly_q [10*L];
  logic        last_dly_q [10*L];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rn_dly_q[0] <= rn;
      for (int i = 1; i < L; i++) rn_dly_q[i] <= rn_dly_q[i-1];
      spec_dly_q[0] <= {spec_in, spec_val_in};
      last_dly_q[0] <= in_i.is_last;
      for (int i = 1; i < 10*L; i++) begin
        spec_dly_q[i] <= spec_dly_q[i-1];
        last_dly_q[i] <= last_dly_q[i-1];
      end
    end
  end

  // ---------------- result select and output register
  logic [32:0] spec_end;
  logic [2:0]  fl_end;
  logic [31:0] res_sel;

  assign spec_end = spec_dly_q[10*L-1];
  assign fl_end   = fl_dly_q[7*L-1];

  always_comb begin
    if (spec_end[32]) begin
      res_sel = spec_end[31:0];
    end else if (fl_end[2]) begin
      res_sel = fl_end[0] ? FpPosInf : 32'd0;
    end else if (fl_end[1]) begin
      res_sel = rs;
    end else begin
      res_sel = rn_dly_q[L-1];
    end
  end

  logic [31:0] exp_q;
  logic        last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      exp_q  <= res_sel;
      last_q <= last_dly_q[10*L-1];
    end
  end

  assign out_o.valid     = vld_q[OutLat-1];
  assign out_o.exp_value = exp_q;
  assign out_o.last_out  = last_q;

endmodule

// ===== rtl/core/sxn_checker.sv =====
// port-level checks for the softmax exponent numerator, bound to the top level
`include "softmax_exp_numerator_defines.svh"

module sxn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] exp_value_i
);

  logic out_nan;

  assign out_nan = (exp_value_i[30:23] == 8'hFF) && (exp_value_i[22:0] != 23'd0);

  // a stalled result stays offered
  `SXN_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  // with the output register empty the pipeline must take input
  `SXN_ASSERT_NOW(a_in_ready, !out_valid_i, in_ready_i, "input blocked with empty output")
  // exponentials are never negative, only nan may carry a sign
  `SXN_ASSERT_NOW(a_no_neg, out_valid_i && exp_value_i[31], out_nan, "negative non-nan result")
  // every nan leaving the block is quiet
  `SXN_ASSERT_NOW(a_quiet_nan, out_valid_i && out_nan, exp_value_i[22], "signaling nan on output")

endmodule

bind softmax_exp_numerator sxn_checker u_sxn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .exp_value_i (out_o.exp_value)
);

// ===== bench/softmax_exp_numerator_tb.sv =====
// self-checking testbench for the softmax exponent numerator
module softmax_exp_numerator_tb
  import sxn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PaddrW-1:0] MaxLogitAddr = {RegMaxLogit, 2'b00};
  localparam int unsigned DrainCycles = 10 * FmaLat + 10;

  typedef struct packed {
    logic [31:0] exp_value;
    logic        last_out;
  } exp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  sxn_in_if  in_if();
  sxn_out_if out_if();

  softmax_exp_numerator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  exp_result_t pending_exps[$];
  logic [31:0] peak_logit;
  int unsigned error_count = 0;
  int unsigned items_sent;
  int unsigned results_seen = 0;
  bit          idle_en;

  // ---------------- binary32 arithmetic on top of real ----------------

  function automatic real f32_to_real(logic [31:0] f);
    real mag;
    if (f[30:23] == 8'hFF)
      return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
    if (f[30:23] == 8'h00) begin
      mag = real'(f[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'b0});
      return f[31] ? -mag : mag;
    end
    return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0});
  endfunction

  // round a double to binary32, nearest even, subnormals kept
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d, sig, q, rem, half;
    logic [31:0] mag;
    int          fe, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? {d[63], 8'hFF, 1'b1, d[50:29]} : {d[63], 8'hFF, 23'b0};
    if (d[62:52] == 11'h000)
      return {d[63], 31'b0};
    fe = int'(d[62:52]) - 1023 + 127;
    if (fe > 254)
      return {d[63], FpPosInf[30:0]};
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 60)
      return {d[63], 31'b0};
    sig  = {11'b0, 1'b1, d[51:0]};
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0]))
      q = q + 64'd1;
    mag = (fe >= 1) ? (32'(fe - 1) << 23) + q[31:0] : q[31:0];
    if (mag >= FpPosInf)
      mag = FpPosInf;
    return {d[63], mag[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_sub(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) - f32_to_real(b));
  endfunction

  // fused a*b+c: exact product, sum rounded to odd, then one rounding
  function automatic logic [31:0] f32_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    real p, cc, s, bb, err;
    logic [63:0] bits;
    p  = f32_to_real(a) * f32_to_real(b);
    cc = f32_to_real(c);
    s  = p + cc;
    if (!(s - s == 0.0))
      return real_to_f32(s);
    bb  = s - p;
    err = (p - (s - bb)) + (cc - bb);
    if (err != 0.0) begin
      bits = $realtobits(s);
      if (!bits[0]) begin
        if ((err > 0.0) == (s > 0.0))
          bits = bits + 64'd1;
        else
          bits = bits - 64'd1;
      end
      s = $bitstoreal(bits);
    end
    return real_to_f32(s);
  endfunction

  // exp approximation: range reduction, polynomial, exponent-field scaling
  function automatic logic [31:0] exp_approx(logic [31:0] x);
    logic [31:0] z, n, nn, b, e, k, an, u, j, g, s1, s2;
    z  = f32_fma(x, FpLog2e, FpShifter);
    n  = f32_sub(z, FpShifter);
    nn = n ^ FpSignMask;
    b  = f32_fma(nn, FpLn2Lo, f32_fma(nn, FpLn2Hi, x));
    e  = z << 23;
    k  = e + FpOne;
    an = n & ~FpSignMask;
    u  = f32_mul(b, b);
    j  = f32_fma(f32_fma(f32_fma(FpC5, b, FpC4), u, f32_fma(FpC3, b, FpC2)), u,
                 f32_mul(FpC1, b));
    if (!(f32_to_real(an) > f32_to_real({1'b0, FpSplitLim})))
      return f32_fma(k, j, k);
    g  = (f32_to_real(n) <= 0.0) ? NegBias : 32'h0;
    s1 = g + S1Base;
    s2 = e - g;
    if (f32_to_real(an) > f32_to_real({1'b0, FpHugeLim}))
      return f32_mul(s1, s1);
    return f32_mul(f32_fma(s2, j, s2), s1);
  endfunction

  function automatic bit f32_is_nan(logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 0;
  endfunction

  function automatic logic [31:0] predict_numerator(logic [31:0] logit, logic [31:0] m);
    if (f32_is_nan(logit))
      return logit | FpQuietBit;
    if (f32_is_nan(m))
      return m | FpQuietBit;
    if (logit[30:0] == FpPosInf[30:0] && logit == m)
      return FpNanSubInf;
    return exp_approx(f32_sub(logit, m));
  endfunction

  // ---------------- drivers ----------------

  task automatic write_peak_logit(logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MaxLogitAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    peak_logit = value;
  endtask

  // send one logit transaction and record its expected numerator
  task automatic send_logit(logic [31:0] logit, logic is_last);
    exp_result_t want;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.logit   <= logit;
    in_if.is_last <= is_last;
    do @(posedge clk_i); while (!in_if.ready);
    want.exp_value = predict_numerator(logit, peak_logit);
    want.last_out  = is_last;
    pending_exps.push_back(want);
    items_sent++;
  endtask

  // lower valid and wait until the pipeline has delivered everything
  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_exps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // output stall bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    exp_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_exps.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result exp_value=%h last_out=%b", $time,
                 out_if.exp_value, out_if.last_out);
      end else begin
        want = pending_exps.pop_front();
        if (out_if.exp_value !== want.exp_value) begin
          error_count++;
          $display("%0t: exp_value expected %h actual %h", $time, want.exp_value,
                   out_if.exp_value);
        end
        if (out_if.last_out !== want.last_out) begin
          error_count++;
          $display("%0t: last_out expected %b actual %b", $time, want.last_out,
                   out_if.last_out);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed_logits();
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
             32'h42B1_7218, 32'h42B2_0000, 32'hC2AE_0000, 32'hC2CE_0000,
             32'hC316_0000, 32'h4302_0000, 32'hC302_0000, 32'h4348_0000,
             32'hC348_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
             32'h8000_0001, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001,
             32'hFFFF_FFFF, 32'h7FC0_0000, 32'h42FC_0000, 32'hC2FC_0000};
    write_peak_logit(32'h0000_0000);
    foreach (vals[i]) send_logit(vals[i], i[0]);
    drain_pipeline();
  endtask

  // infinities and NaNs in the subtracted maximum
  task automatic test_special_max();
    write_peak_logit(FpPosInf);
    send_logit(FpPosInf, 1'b0);
    send_logit(32'h3F80_0000, 1'b0);
    send_logit(32'hFF80_0000, 1'b1);
    drain_pipeline();
    write_peak_logit(32'hFF80_0000);
    send_logit(32'hFF80_0000, 1'b0);
    send_logit(32'h3F80_0000, 1'b1);
    drain_pipeline();
    write_peak_logit(32'h7F80_0001);
    send_logit(32'h3F80_0000, 1'b0);
    send_logit(32'hFFA0_0000, 1'b1);
    drain_pipeline();
  endtask

  // mostly logits a moderate distance from the maximum, some raw bit patterns
  task automatic test_random_vectors(logic [31:0] m, int unsigned count, bit pause_midway);
    logic [31:0] logit;
    real         d;
    write_peak_logit(m);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7 && m[30:23] != 8'hFF) begin
        d = (real'($urandom_range(0, 300000)) / 1000.0) - 200.0;
        logit = real_to_f32(f32_to_real(m) + d);
      end else begin
        logit = $urandom;
      end
      send_logit(logit, $urandom_range(0, 7) == 0);
      if (pause_midway && i == count / 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_exps.size() != 0) @(posedge clk_i);
      end
    end
    drain_pipeline();
  endtask

  initial begin
    items_sent  = 0;
    idle_en     = 1'b1;
    peak_logit  = 32'h0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.logit   <= '0;
    in_if.is_last <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_logits();
    test_special_max();
    test_random_vectors(32'h0000_0000, 100, 1'b1);
    test_random_vectors(32'h4120_0000, 100, 1'b0);
    test_random_vectors(32'hC2C8_0000, 100, 1'b0);
    test_random_vectors(32'h7F7F_FFFF, 60, 1'b0);
    test_random_vectors(32'hFFFF_FFFF, 40, 1'b0);
    test_random_vectors($urandom, 80, 1'b0);
    idle_en = 1'b0;
    test_random_vectors(32'h0000_0001, 120, 1'b0);

    $display("covered %0d logits and %0d results over directed, special-maximum",
             items_sent, results_seen);
    $display("and randomized maximum settings with input gaps and output stalls");
    if (error_count == 0 && pending_exps.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
